// ===== sv/vau_pkg.sv =====
// shared widths and operation/status codes for the vector arithmetic unit
package vau_pkg;

	localparam int DATA_W   = 32;
	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 2;
	localparam int ROOT_W   = 32;
	localparam int RAD_W    = 2 * ROOT_W;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD   = 3'd0,
		FN_SUB   = 3'd1,
		FN_SCALE = 3'd2,
		FN_DIV   = 3'd3,
		FN_LEN   = 3'd4,
		FN_NORM  = 3'd5,
		FN_DOT   = 3'd6,
		FN_CROSS = 3'd7
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_DIV_ZERO = 2'd1,
		ST_OVF      = 2'd2
	} status_t;

endpackage

// ===== sv/vau_in_if.sv =====
// request channel carrying operation code, two vectors and a scalar
interface vau_in_if;
	import vau_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic signed [DATA_W-1:0] ax;
	logic signed [DATA_W-1:0] ay;
	logic signed [DATA_W-1:0] az;
	logic signed [DATA_W-1:0] bx;
	logic signed [DATA_W-1:0] by_comp;
	logic signed [DATA_W-1:0] bz;
	logic signed [DATA_W-1:0] scale_value;

	modport source (output valid, func, ax, ay, az, bx, by_comp, bz, scale_value, input ready);
	modport sink (input valid, func, ax, ay, az, bx, by_comp, bz, scale_value, output ready);

endinterface

// ===== sv/vau_out_if.sv =====
// result channel carrying vector result, scalar result and status
interface vau_out_if;
	import vau_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] rx;
	logic signed [DATA_W-1:0] ry;
	logic signed [DATA_W-1:0] rz;
	logic signed [DATA_W-1:0] scalar_result;
	logic [STATUS_W-1:0]      status;

	modport source (output valid, rx, ry, rz, scalar_result, status, input ready);
	modport sink (input valid, rx, ry, rz, scalar_result, status, output ready);

endinterface

// ===== sv/vau_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module vau_sqrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [vau_pkg::RAD_W-1:0]  radicand,
	output logic [vau_pkg::ROOT_W-1:0] root
);
	import vau_pkg::*;

	localparam int ST = ROOT_W;

	logic [RAD_W-1:0] rem_s [1:ST-1];
	logic [RAD_W-1:0] res_s [1:ST];

	for (genvar g = 0; g < ST; g++) begin : g_step
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (ST - 1 - g));
		logic [RAD_W-1:0] cur_rem;
		logic [RAD_W-1:0] cur_res;
		logic [RAD_W-1:0] trial;
		logic             take;

		if (g == 0) begin : g_first
			assign cur_rem = radicand;
			assign cur_res = '0;
		end else begin : g_next
			assign cur_rem = rem_s[g];
			assign cur_res = res_s[g];
		end

		assign trial = cur_res + BIT;
		assign take  = (cur_rem >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				res_s[g+1] <= take ? ((cur_res >> 1) + BIT) : (cur_res >> 1);
			end
		end

		if (g < ST - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g+1] <= take ? (cur_rem - trial) : cur_rem;
				end
			end
		end
	end

	assign root = res_s[ST][ROOT_W-1:0];

endmodule

// ===== sv/vau_div.sv =====
// pipelined restoring divider, 32 quotient bits with an overflow precheck
module vau_div #(
	parameter int DVD_W = 48
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [DVD_W-1:0]          dividend,
	input  logic [vau_pkg::DATA_W-1:0] divisor,
	output logic [vau_pkg::DATA_W-1:0] quotient,
	output logic                      ovf
);
	import vau_pkg::*;

	localparam int QW = DATA_W;
	localparam int CW = DVD_W + QW;

	logic [DVD_W-1:0] rem_s [0:QW-1];
	logic [QW-1:0]    dvr_s [0:QW-1];
	logic [QW-1:0]    q_s   [0:QW];
	logic             ovf_s [0:QW];

	// quotient of 2^32 or more saturates whatever the sign
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= dividend;
			dvr_s[0] <= divisor;
			q_s[0]   <= '0;
			ovf_s[0] <= (CW'(dividend) >= (CW'(divisor) << QW));
		end
	end

	for (genvar g = 0; g < QW; g++) begin : g_step
		localparam int SH = QW - 1 - g;
		logic [CW-1:0] lsh;
		logic          ge;

		assign lsh = CW'(dvr_s[g]) << SH;
		assign ge  = (CW'(rem_s[g]) >= lsh);

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[g+1]   <= {q_s[g][QW-2:0], ge};
				ovf_s[g+1] <= ovf_s[g];
			end
		end

		if (g < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g+1] <= ge ? DVD_W'(CW'(rem_s[g]) - lsh) : rem_s[g];
					dvr_s[g+1] <= dvr_s[g];
				end
			end
		end
	end

	assign quotient = q_s[QW];
	assign ovf      = ovf_s[QW];

endmodule

// ===== sv/vector3_arithmetic_unit.sv =====
// top level of the pipelined Q-format 3d vector arithmetic unit
//
//  channel   | dir | handshake    | payload
//  in_ch     | in  | valid/ready  | func, ax, ay, az, bx, by_comp, bz, scale_value
//  out_ch    | out | valid/ready  | rx, ry, rz, scalar_result, status
//
// one request per cycle unless a stalled result holds the pipe
// depth is set by the 32-stage square root and the 33-stage divider
// arst_n clears all valid bits, data registers are not reset
// a stalled result freezes the pipe, the first stage still fills a bubble
module vector3_arithmetic_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	vau_in_if.sink    in_ch,
	vau_out_if.source out_ch
);
	import vau_pkg::*;

	localparam int DVW    = DATA_W + FRAC_BITS;
	localparam int SQ_LAT = ROOT_W;
	localparam int DV_LAT = DATA_W + 1;
	localparam int WW     = 2 * DATA_W + 2;

	localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [WW-1:0]     OVF_MAG = WW'(1) << DATA_W;

	typedef struct packed {
		logic             ovf;
		logic [DATA_W-1:0] val;
	} fin_t;

	typedef struct packed {
		func_t                  fn;
		logic [2:0]             an;
		logic [2:0][DATA_W-1:0] am;
		logic                   sn;
		logic [DATA_W-1:0]      sm;
		logic [2:0][DATA_W-1:0] r;
		logic [DATA_W-1:0]      sc;
		logic                   ovf;
	} side_t;

	typedef struct packed {
		func_t                  fn;
		logic [2:0]             neg;
		logic [2:0][DATA_W-1:0] r;
		logic [DATA_W-1:0]      sc;
		logic                   ovf;
		logic                   dz;
	} tail_t;

	function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
		return x[DATA_W-1] ? (DATA_W'(0) - x) : x;
	endfunction

	function automatic logic [WW-1:0] sx(input logic neg, input logic [2*DATA_W-1:0] m);
		return neg ? (WW'(0) - WW'(m)) : WW'(m);
	endfunction

	function automatic logic [WW-1:0] mag_sh(input logic [WW-1:0] w, input logic sh);
		logic [WW-1:0] m;
		m = w[WW-1] ? (WW'(0) - w) : w;
		return sh ? (m >> FRAC_BITS) : m;
	endfunction

	function automatic fin_t sat_fin(input logic neg, input logic [WW-1:0] m);
		fin_t f;
		f.ovf = 1'b0;
		f.val = m[DATA_W-1:0];
		if (!neg) begin
			if (m > WW'(MAX_POS)) begin
				f.ovf = 1'b1;
				f.val = MAX_POS;
			end
		end else if (m > WW'(MIN_NEG)) begin
			f.ovf = 1'b1;
			f.val = MIN_NEG;
		end else begin
			f.val = DATA_W'(0) - m[DATA_W-1:0];
		end
		return f;
	endfunction

	logic en;
	logic en1;

	logic                   v_s1, v_s2, v_s3, v_s6;
	logic [SQ_LAT-1:0]      sq_v_s;
	logic [DV_LAT-1:0]      dv_v_s;

	// stage 1: registered request with magnitudes
	func_t                  fn_s1;
	logic [2:0][DATA_W-1:0] a_s1, b_s1, am_s1, bm_s1;
	logic [2:0]             an_s1, bn_s1;
	logic [DATA_W-1:0]      sm_s1;
	logic                   sn_s1;

	// stage 2: products and sums
	logic [5:0][DATA_W-1:0]   op_x, op_y;
	logic [5:0]               op_n;
	logic [2:0][DATA_W:0]     as_n;
	func_t                    fn_s2;
	logic [5:0][2*DATA_W-1:0] p_s2;
	logic [5:0]               pn_s2;
	logic [2:0][DATA_W:0]     as_s2;
	logic [2:0][DATA_W-1:0]   am_s2;
	logic [2:0]               an_s2;
	logic [DATA_W-1:0]        sm_s2;
	logic                     sn_s2;

	// stage 3: signed wide values
	logic [2:0][WW-1:0]     w_n;
	func_t                  fn_s3;
	logic [2:0][WW-1:0]     w_s3;
	logic [2:0][DATA_W-1:0] am_s3;
	logic [2:0]             an_s3;
	logic [DATA_W-1:0]      sm_s3;
	logic                   sn_s3;

	// stage 4 onward
	logic  sh4, is_vec4;
	fin_t  f4_0, f4_1, f4_2;
	side_t side_n4;
	side_t sq_side_s [SQ_LAT];
	logic [ROOT_W-1:0] root;

	side_t                  sd5;
	fin_t                   flen;
	tail_t                  tail_n5;
	logic [DATA_W-1:0]      dvr5;
	tail_t                  dv_tail_s [DV_LAT];
	logic [DATA_W-1:0]      quo [3];
	logic                   qovf [3];
	fin_t                   fq [3];

	tail_t                  td;
	logic                   is_div6, ovf6;
	logic [2:0][DATA_W-1:0] r_s6;
	logic [DATA_W-1:0]      sc_s6;
	status_t                status_s6;

	assign en          = !v_s6 || out_ch.ready;
	assign en1         = !v_s1 || en;
	assign in_ch.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			sq_v_s <= '0;
			dv_v_s <= '0;
			v_s6   <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_ch.valid;
			end
			if (en) begin
				v_s2   <= v_s1;
				v_s3   <= v_s2;
				sq_v_s <= {sq_v_s[SQ_LAT-2:0], v_s3};
				dv_v_s <= {dv_v_s[DV_LAT-2:0], sq_v_s[SQ_LAT-1]};
				v_s6   <= dv_v_s[DV_LAT-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			fn_s1    <= func_t'(in_ch.func);
			a_s1[0]  <= in_ch.ax;
			a_s1[1]  <= in_ch.ay;
			a_s1[2]  <= in_ch.az;
			b_s1[0]  <= in_ch.bx;
			b_s1[1]  <= in_ch.by_comp;
			b_s1[2]  <= in_ch.bz;
			am_s1[0] <= mag32(in_ch.ax);
			am_s1[1] <= mag32(in_ch.ay);
			am_s1[2] <= mag32(in_ch.az);
			bm_s1[0] <= mag32(in_ch.bx);
			bm_s1[1] <= mag32(in_ch.by_comp);
			bm_s1[2] <= mag32(in_ch.bz);
			an_s1    <= {in_ch.az[DATA_W-1], in_ch.ay[DATA_W-1], in_ch.ax[DATA_W-1]};
			bn_s1    <= {in_ch.bz[DATA_W-1], in_ch.by_comp[DATA_W-1], in_ch.bx[DATA_W-1]};
			sm_s1    <= mag32(in_ch.scale_value);
			sn_s1    <= in_ch.scale_value[DATA_W-1];
		end
	end

	// multiplier operand selection
	always_comb begin
		op_x = '0;
		op_y = '0;
		op_n = '0;
		unique case (fn_s1)
			FN_SCALE: begin
				op_x[2:0] = am_s1;
				op_y[0]   = sm_s1;
				op_y[1]   = sm_s1;
				op_y[2]   = sm_s1;
				op_n[2:0] = an_s1 ^ {3{sn_s1}};
			end
			FN_LEN, FN_NORM: begin
				op_x[2:0] = am_s1;
				op_y[2:0] = am_s1;
			end
			FN_DOT: begin
				op_x[2:0] = am_s1;
				op_y[2:0] = bm_s1;
				op_n[2:0] = an_s1 ^ bn_s1;
			end
			FN_CROSS: begin
				op_x[0] = am_s1[1]; op_y[0] = bm_s1[2]; op_n[0] = an_s1[1] ^ bn_s1[2];
				op_x[3] = am_s1[2]; op_y[3] = bm_s1[1]; op_n[3] = an_s1[2] ^ bn_s1[1];
				op_x[1] = am_s1[2]; op_y[1] = bm_s1[0]; op_n[1] = an_s1[2] ^ bn_s1[0];
				op_x[4] = am_s1[0]; op_y[4] = bm_s1[2]; op_n[4] = an_s1[0] ^ bn_s1[2];
				op_x[2] = am_s1[0]; op_y[2] = bm_s1[1]; op_n[2] = an_s1[0] ^ bn_s1[1];
				op_x[5] = am_s1[1]; op_y[5] = bm_s1[0]; op_n[5] = an_s1[1] ^ bn_s1[0];
			end
			default: begin
			end
		endcase
	end

	for (genvar g = 0; g < 3; g++) begin : g_addsub
		logic [DATA_W:0] sa, sb;
		assign sa      = {a_s1[g][DATA_W-1], a_s1[g]};
		assign sb      = {b_s1[g][DATA_W-1], b_s1[g]};
		assign as_n[g] = (fn_s1 == FN_SUB) ? (sa - sb) : (sa + sb);
	end

	for (genvar g = 0; g < 6; g++) begin : g_mul
		always_ff @(posedge clk) begin
			if (en) begin
				p_s2[g] <= op_x[g] * op_y[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fn_s2 <= fn_s1;
			pn_s2 <= op_n;
			as_s2 <= as_n;
			am_s2 <= am_s1;
			an_s2 <= an_s1;
			sm_s2 <= sm_s1;
			sn_s2 <= sn_s1;
		end
	end

	// signed combination of products, or sign-extended sums for add and subtract
	always_comb begin
		w_n = '0;
		unique case (fn_s2)
			FN_ADD, FN_SUB: begin
				w_n[0] = {{(WW-DATA_W-1){as_s2[0][DATA_W]}}, as_s2[0]};
				w_n[1] = {{(WW-DATA_W-1){as_s2[1][DATA_W]}}, as_s2[1]};
				w_n[2] = {{(WW-DATA_W-1){as_s2[2][DATA_W]}}, as_s2[2]};
			end
			FN_SCALE: begin
				w_n[0] = sx(pn_s2[0], p_s2[0]);
				w_n[1] = sx(pn_s2[1], p_s2[1]);
				w_n[2] = sx(pn_s2[2], p_s2[2]);
			end
			FN_LEN, FN_NORM: begin
				w_n[0] = WW'(p_s2[0]) + WW'(p_s2[1]) + WW'(p_s2[2]);
			end
			FN_DOT: begin
				w_n[0] = sx(pn_s2[0], p_s2[0]) + sx(pn_s2[1], p_s2[1]) + sx(pn_s2[2], p_s2[2]);
			end
			FN_CROSS: begin
				w_n[0] = sx(pn_s2[0], p_s2[0]) - sx(pn_s2[3], p_s2[3]);
				w_n[1] = sx(pn_s2[1], p_s2[1]) - sx(pn_s2[4], p_s2[4]);
				w_n[2] = sx(pn_s2[2], p_s2[2]) - sx(pn_s2[5], p_s2[5]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fn_s3 <= fn_s2;
			w_s3  <= w_n;
			am_s3 <= am_s2;
			an_s3 <= an_s2;
			sm_s3 <= sm_s2;
			sn_s3 <= sn_s2;
		end
	end

	// truncate and saturate the add, subtract, scale, dot and cross results
	always_comb begin
		sh4     = !(fn_s3 == FN_ADD || fn_s3 == FN_SUB);
		is_vec4 = (fn_s3 == FN_ADD || fn_s3 == FN_SUB || fn_s3 == FN_SCALE
			|| fn_s3 == FN_CROSS);
		f4_0    = sat_fin(w_s3[0][WW-1], mag_sh(w_s3[0], sh4));
		f4_1    = sat_fin(w_s3[1][WW-1], mag_sh(w_s3[1], sh4));
		f4_2    = sat_fin(w_s3[2][WW-1], mag_sh(w_s3[2], sh4));
		side_n4.fn  = fn_s3;
		side_n4.an  = an_s3;
		side_n4.am  = am_s3;
		side_n4.sn  = (fn_s3 == FN_DIV) && sn_s3;
		side_n4.sm  = sm_s3;
		side_n4.r   = is_vec4 ? {f4_2.val, f4_1.val, f4_0.val} : '0;
		side_n4.sc  = (fn_s3 == FN_DOT) ? f4_0.val : '0;
		side_n4.ovf = (is_vec4 && (f4_0.ovf || f4_1.ovf || f4_2.ovf))
			|| (fn_s3 == FN_DOT && f4_0.ovf);
	end

	vau_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (w_s3[0][RAD_W-1:0]),
		.root     (root)
	);

	for (genvar g = 0; g < SQ_LAT; g++) begin : g_sq_side
		always_ff @(posedge clk) begin
			if (en) begin
				if (g == 0) begin
					sq_side_s[g] <= side_n4;
				end else begin
					sq_side_s[g] <= sq_side_s[(g == 0) ? 0 : g - 1];
				end
			end
		end
	end

	// length result and divisor choice
	always_comb begin
		sd5             = sq_side_s[SQ_LAT-1];
		flen            = sat_fin(1'b0, WW'(root));
		tail_n5.fn      = sd5.fn;
		tail_n5.neg     = sd5.an ^ {3{sd5.sn}};
		tail_n5.r       = sd5.r;
		tail_n5.sc      = (sd5.fn == FN_LEN) ? flen.val : sd5.sc;
		tail_n5.ovf     = sd5.ovf || (sd5.fn == FN_LEN && flen.ovf);
		tail_n5.dz      = (sd5.fn == FN_DIV && sd5.sm == '0)
			|| (sd5.fn == FN_NORM && root == '0);
		dvr5            = (sd5.fn == FN_DIV) ? sd5.sm : root;
	end

	for (genvar g = 0; g < 3; g++) begin : g_div
		vau_div #(
			.DVD_W (DVW)
		) u_div (
			.clk      (clk),
			.en       (en),
			.dividend ({sd5.am[g], {FRAC_BITS{1'b0}}}),
			.divisor  (dvr5),
			.quotient (quo[g]),
			.ovf      (qovf[g])
		);

		assign fq[g] = sat_fin(td.neg[g], qovf[g] ? OVF_MAG : WW'(quo[g]));
	end

	for (genvar g = 0; g < DV_LAT; g++) begin : g_dv_tail
		always_ff @(posedge clk) begin
			if (en) begin
				if (g == 0) begin
					dv_tail_s[g] <= tail_n5;
				end else begin
					dv_tail_s[g] <= dv_tail_s[(g == 0) ? 0 : g - 1];
				end
			end
		end
	end

	always_comb begin
		td      = dv_tail_s[DV_LAT-1];
		is_div6 = (td.fn == FN_DIV || td.fn == FN_NORM);
		ovf6    = td.ovf || (is_div6 && !td.dz && (fq[0].ovf || fq[1].ovf || fq[2].ovf));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s6  <= (is_div6 && !td.dz) ? {fq[2].val, fq[1].val, fq[0].val} : td.r;
			sc_s6 <= td.sc;
			if (td.dz) begin
				status_s6 <= ST_DIV_ZERO;
			end else if (ovf6) begin
				status_s6 <= ST_OVF;
			end else begin
				status_s6 <= ST_OK;
			end
		end
	end

	assign out_ch.valid         = v_s6;
	assign out_ch.rx            = r_s6[0];
	assign out_ch.ry            = r_s6[1];
	assign out_ch.rz            = r_s6[2];
	assign out_ch.scalar_result = sc_s6;
	assign out_ch.status        = status_s6;

endmodule

// ===== sv/vau_check.sv =====
// port-level checks for the vector arithmetic unit, bound to the top level
module vau_check (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [vau_pkg::DATA_W-1:0] rx,
	input logic [vau_pkg::DATA_W-1:0] ry,
	input logic [vau_pkg::DATA_W-1:0] rz,
	input logic [vau_pkg::DATA_W-1:0] scalar_result,
	input logic [vau_pkg::STATUS_W-1:0] status
);
	import vau_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rx) && $stable(ry)
			&& $stable(rz) && $stable(scalar_result) && $stable(status))
		else $error("stalled result changed");

	// no result while in reset
	a_rst: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// divide by zero gives all-zero fields
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DIV_ZERO |-> rx == '0 && ry == '0 && rz == '0
			&& scalar_result == '0)
		else $error("divide by zero with nonzero result");

	// scalar and vector results never both present
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scalar_result != '0 |-> rx == '0 && ry == '0 && rz == '0)
		else $error("scalar and vector result both set");

endmodule

bind vector3_arithmetic_unit vau_check u_vau_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.rx            (out_ch.rx),
	.ry            (out_ch.ry),
	.rz            (out_ch.rz),
	.scalar_result (out_ch.scalar_result),
	.status        (out_ch.status)
);

// ===== dv/vau_tb_if.sv =====
`timescale 1ns / 100ps
// testbench package with the packed request and result types
package vau_tb_pkg;
	import vau_pkg::*;

	typedef struct packed {
		func_t                    func;
		logic signed [DATA_W-1:0] ax;
		logic signed [DATA_W-1:0] ay;
		logic signed [DATA_W-1:0] az;
		logic signed [DATA_W-1:0] bx;
		logic signed [DATA_W-1:0] by_comp;
		logic signed [DATA_W-1:0] bz;
		logic signed [DATA_W-1:0] scale_value;
	} vec_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] rx;
		logic signed [DATA_W-1:0] ry;
		logic signed [DATA_W-1:0] rz;
		logic signed [DATA_W-1:0] scalar_result;
		status_t                  status;
	} vec_rsp_t;

endpackage

// ===== dv/tb_vector3_arithmetic_unit.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the vector arithmetic unit with a fixed-point predictor
module tb_vector3_arithmetic_unit;
	import vau_pkg::*;
	import vau_tb_pkg::*;

	localparam int FRAC     = 16;
	localparam int LATENCY  = 69;
	localparam int N_RANDOM = 1400;
	localparam logic signed [31:0] MAXV = 32'sh7fffffff;
	localparam logic signed [31:0] MINV = 32'sh80000000;
	localparam logic signed [31:0] ONE  = 32'sh00010000;

	logic clk;
	logic arst_n;
	vau_in_if  in_ch();
	vau_out_if out_ch();

	vector3_arithmetic_unit #(.FRAC_BITS(FRAC)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	vec_rsp_t expected_q[$];
	int       errors;
	bit       stim_done;
	int       hold_off;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// magnitude and sign of the exact wide value, truncated then saturated
	function automatic logic [31:0] sat_trunc(input logic signed [127:0] v, input int sh,
			inout bit ovf);
		logic [127:0] mag;
		mag = v[127] ? -v : v;
		mag = mag >> sh;
		if (!v[127]) begin
			if (mag > 128'h7fffffff) begin
				ovf = 1;
				return 32'h7fffffff;
			end
			return mag[31:0];
		end
		if (mag > 128'h80000000) begin
			ovf = 1;
			return 32'h80000000;
		end
		return -mag[31:0];
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [127:0] n);
		logic [127:0] res;
		logic [127:0] b;
		res = 0;
		b = 128'd1 << 126;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res[63:0];
	endfunction

	function automatic logic signed [127:0] quot(input logic signed [31:0] a,
			input logic [127:0] dmag, input bit dneg);
		logic [127:0] am;
		logic [127:0] q;
		am = a[31] ? -{{96{a[31]}}, a} : {96'd0, a};
		q = (am << FRAC) / dmag;
		return (a[31] != dneg) ? -$signed(q) : $signed(q);
	endfunction

	function automatic vec_rsp_t predict_vector_op(input vec_req_t q);
		vec_rsp_t r;
		logic signed [127:0] a[3];
		logic signed [127:0] b[3];
		logic signed [127:0] s;
		logic signed [127:0] acc;
		logic [127:0] smag;
		logic [63:0] len;
		bit ovf;
		bit dz;
		logic [31:0] rv[3];
		a[0] = q.ax; a[1] = q.ay; a[2] = q.az;
		b[0] = q.bx; b[1] = q.by_comp; b[2] = q.bz;
		s = q.scale_value;
		ovf = 0;
		dz = 0;
		rv[0] = 0; rv[1] = 0; rv[2] = 0;
		r.scalar_result = 0;
		case (q.func)
			FN_ADD: for (int i = 0; i < 3; i++) rv[i] = sat_trunc(a[i] + b[i], 0, ovf);
			FN_SUB: for (int i = 0; i < 3; i++) rv[i] = sat_trunc(a[i] - b[i], 0, ovf);
			FN_SCALE: for (int i = 0; i < 3; i++) rv[i] = sat_trunc(a[i] * s, FRAC, ovf);
			FN_DIV: begin
				if (s == 0) begin
					dz = 1;
				end else begin
					smag = s[127] ? -s : s;
					for (int i = 0; i < 3; i++)
						rv[i] = sat_trunc(quot(a[i][31:0], smag, s[127]), 0, ovf);
				end
			end
			FN_LEN, FN_NORM: begin
				len = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
				if (q.func == FN_LEN) begin
					r.scalar_result = sat_trunc({64'd0, len}, 0, ovf);
				end else if (len == 0) begin
					dz = 1;
				end else begin
					for (int i = 0; i < 3; i++)
						rv[i] = sat_trunc(quot(a[i][31:0], {64'd0, len}, 0), 0, ovf);
				end
			end
			FN_DOT: begin
				acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
				r.scalar_result = sat_trunc(acc, FRAC, ovf);
			end
			default: begin
				for (int i = 0; i < 3; i++) begin
					acc = a[(i + 1) % 3] * b[(i + 2) % 3] - a[(i + 2) % 3] * b[(i + 1) % 3];
					rv[i] = sat_trunc(acc, FRAC, ovf);
				end
			end
		endcase
		r.rx = rv[0];
		r.ry = rv[1];
		r.rz = rv[2];
		r.status = dz ? ST_DIV_ZERO : (ovf ? ST_OVF : ST_OK);
		return r;
	endfunction

	function automatic logic [31:0] rand_component(input int shape);
		case (shape)
			0: return $urandom();
			1: return $urandom_range(0, 32'h0003ffff) - 32'h00020000;
			2: return $urandom_range(0, 32'h03ffffff) - 32'h02000000;
			3: return ($urandom_range(0, 1) ? MAXV : MINV) - $urandom_range(0, 3);
			default: return 0;
		endcase
	endfunction

	task automatic send_request(input vec_req_t q);
		in_ch.valid       <= 1'b1;
		in_ch.func        <= q.func;
		in_ch.ax          <= q.ax;
		in_ch.ay          <= q.ay;
		in_ch.az          <= q.az;
		in_ch.bx          <= q.bx;
		in_ch.by_comp     <= q.by_comp;
		in_ch.bz          <= q.bz;
		in_ch.scale_value <= q.scale_value;
		do
			@(posedge clk);
		while (!in_ch.ready);
		expected_q.push_back(predict_vector_op(q));
	endtask

	task automatic idle_gap(input bit allow);
		while (allow && $urandom_range(0, 99) < 28) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	typedef struct {
		vec_req_t q;
		bit       known;
		vec_rsp_t r;
	} directed_row_t;

	directed_row_t directed[$];

	function automatic vec_req_t mk(input func_t f, input logic [31:0] ax, ay, az, bx, by_c,
			bz, sv);
		vec_req_t q;
		q.func = f; q.ax = ax; q.ay = ay; q.az = az;
		q.bx = bx; q.by_comp = by_c; q.bz = bz; q.scale_value = sv;
		return q;
	endfunction

	function automatic vec_rsp_t rs(input logic [31:0] rx, ry, rz, sc, input status_t st);
		vec_rsp_t r;
		r.rx = rx; r.ry = ry; r.rz = rz; r.scalar_result = sc; r.status = st;
		return r;
	endfunction

	task automatic add_row(input vec_req_t q, input bit known, input vec_rsp_t r);
		directed_row_t d;
		d.q = q;
		d.known = known;
		d.r = r;
		directed.push_back(d);
	endtask

	task automatic build_directed();
		vec_rsp_t none;
		none = '0;
		add_row(mk(FN_ADD, 0, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 0, ST_OK));
		add_row(mk(FN_ADD, MAXV, MINV, 1, 1, -1, 2, 0), 1, rs(MAXV, MINV, 3, 0, ST_OVF));
		add_row(mk(FN_SUB, MINV, MAXV, 5, 1, -1, 7, 0), 1, rs(MINV, MAXV, -2, 0, ST_OVF));
		add_row(mk(FN_SUB, MAXV, 0, MINV, MAXV, MINV, MINV, 0), 0, none);
		add_row(mk(FN_SCALE, ONE, -ONE, MAXV, 0, 0, 0, ONE), 1,
			rs(ONE, -ONE, MAXV, 0, ST_OK));
		add_row(mk(FN_SCALE, MAXV, MINV, ONE, 0, 0, 0, MINV), 0, none);
		add_row(mk(FN_DIV, ONE, MAXV, MINV, 0, 0, 0, 0), 1, rs(0, 0, 0, 0, ST_DIV_ZERO));
		add_row(mk(FN_DIV, ONE, -ONE, 3 * ONE, 0, 0, 0, ONE), 1,
			rs(ONE, -ONE, 3 * ONE, 0, ST_OK));
		add_row(mk(FN_DIV, MAXV, MINV, -7, 0, 0, 0, 1), 0, none);
		add_row(mk(FN_DIV, MINV, -1, 7, 0, 0, 0, MINV), 0, none);
		add_row(mk(FN_LEN, 0, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 0, ST_OK));
		add_row(mk(FN_LEN, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0), 1,
			rs(0, 0, 0, 5 * ONE, ST_OK));
		add_row(mk(FN_LEN, MINV, MINV, MINV, 0, 0, 0, 0), 1, rs(0, 0, 0, MAXV, ST_OVF));
		add_row(mk(FN_NORM, 0, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 0, ST_DIV_ZERO));
		add_row(mk(FN_NORM, 0, -2 * ONE, 0, 0, 0, 0, 0), 1, rs(0, -ONE, 0, 0, ST_OK));
		add_row(mk(FN_NORM, 1, 0, 0, 0, 0, 0, 0), 0, none);
		add_row(mk(FN_NORM, MAXV, MINV, 1, 0, 0, 0, 0), 0, none);
		add_row(mk(FN_DOT, ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 0), 1,
			rs(0, 0, 0, 32 * ONE, ST_OK));
		add_row(mk(FN_DOT, MINV, MINV, MINV, MINV, MINV, MINV, 0), 1,
			rs(0, 0, 0, MAXV, ST_OVF));
		add_row(mk(FN_DOT, MAXV, MINV, MAXV, MINV, MINV, MINV, 0), 0, none);
		add_row(mk(FN_CROSS, ONE, 0, 0, 0, ONE, 0, 0), 1, rs(0, 0, ONE, 0, ST_OK));
		add_row(mk(FN_CROSS, MINV, MAXV, MINV, MAXV, MINV, MAXV, -1), 0, none);
	endtask

	initial begin
		vec_req_t q;
		int shape;
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.func        = FN_ADD;
		in_ch.ax          = '0;
		in_ch.ay          = '0;
		in_ch.az          = '0;
		in_ch.bx          = '0;
		in_ch.by_comp     = '0;
		in_ch.bz          = '0;
		in_ch.scale_value = '0;
		errors = 0;
		stim_done = 0;
		build_directed();
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			send_request(directed[i].q);
			if (directed[i].known && predict_vector_op(directed[i].q) != directed[i].r)
				void'(expected_q.pop_back());
			if (directed[i].known && predict_vector_op(directed[i].q) != directed[i].r)
				expected_q.push_back(directed[i].r);
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			shape = $urandom_range(0, 4);
			q.func = func_t'($urandom_range(0, 7));
			q.ax = rand_component(shape);
			q.ay = rand_component(shape);
			q.az = rand_component(shape);
			q.bx = rand_component(shape);
			q.by_comp = rand_component(shape);
			q.bz = rand_component(shape);
			q.scale_value = ($urandom_range(0, 15) == 0) ? 0 : rand_component(shape);
			send_request(q);
			if (n == 700) begin
				in_ch.valid <= 1'b0;
				wait (expected_q.size() == 0);
				@(posedge clk);
			end else begin
				idle_gap(!(n > 300 && n < 500));
			end
		end
		in_ch.valid <= 1'b0;
		stim_done = 1;
	end

	initial begin
		vec_rsp_t got;
		vec_rsp_t exp_r;
		int cnt;
		out_ch.ready = 1'b0;
		cnt = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got.rx = out_ch.rx;
				got.ry = out_ch.ry;
				got.rz = out_ch.rz;
				got.scalar_result = out_ch.scalar_result;
				got.status = status_t'(out_ch.status);
				cnt++;
				if (expected_q.size() == 0) begin
					errors++;
					$display("%t unexpected result %h", $time, got);
				end else begin
					exp_r = expected_q.pop_front();
					if (got.rx !== exp_r.rx)
						$display("%t rx exp %h got %h", $time, exp_r.rx, got.rx);
					if (got.ry !== exp_r.ry)
						$display("%t ry exp %h got %h", $time, exp_r.ry, got.ry);
					if (got.rz !== exp_r.rz)
						$display("%t rz exp %h got %h", $time, exp_r.rz, got.rz);
					if (got.scalar_result !== exp_r.scalar_result)
						$display("%t scalar exp %h got %h", $time,
							exp_r.scalar_result, got.scalar_result);
					if (got.status !== exp_r.status)
						$display("%t status exp %0d got %0d", $time,
							exp_r.status, got.status);
					if (got !== exp_r)
						errors++;
				end
			end
			// long hold-off once the pipe has seen some traffic
			if (cnt == 200 && hold_off == 0) begin
				hold_off = 1;
				out_ch.ready <= 1'b0;
				repeat (300)
					@(posedge clk);
			end
			if (cnt > 300 && cnt < 500)
				out_ch.ready <= 1'b1;
			else
				out_ch.ready <= ($urandom_range(0, 99) >= 28);
		end
	end

	initial begin
		hold_off = 0;
		wait (stim_done);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20)
			@(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
